/* hw/rtl/slx_pkg.sv */
// shared types, codes and keyword tables for the source lexer
`default_nettype none
package slx_pkg;

  typedef enum logic [3:0] {
    TK_END     = 4'd0,
    TK_NEWLINE = 4'd1,
    TK_IDENT   = 4'd2,
    TK_KEYWORD = 4'd3,
    TK_INT     = 4'd4,
    TK_FLOAT   = 4'd5,
    TK_STRING  = 4'd6,
    TK_COMMA   = 4'd7,
    TK_COLON   = 4'd8,
    TK_OPEN    = 4'd9,
    TK_CLOSE   = 4'd10,
    TK_ASSIGN  = 4'd11,
    TK_OPER    = 4'd12,
    TK_DIAG    = 4'd13
  } tk_t;

  typedef enum logic [3:0] {
    MD_IDLE   = 4'd0,
    MD_IDENT  = 4'd1,
    MD_NUMBER = 4'd2,
    MD_STRING = 4'd3,
    MD_HASH   = 4'd4,
    MD_LINE   = 4'd5,
    MD_BLOCK  = 4'd6,
    MD_OPER   = 4'd7
  } mode_t;

  typedef enum logic [1:0] {
    PO_EQ   = 2'd0,
    PO_LT   = 2'd1,
    PO_GT   = 2'd2,
    PO_BANG = 2'd3
  } popr_t;

  // operator sub codes
  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_EQ  = 5'd4;
  localparam logic [4:0] OP_NE  = 5'd5;
  localparam logic [4:0] OP_LT  = 5'd6;
  localparam logic [4:0] OP_LE  = 5'd7;
  localparam logic [4:0] OP_GT  = 5'd8;
  localparam logic [4:0] OP_GE  = 5'd9;

  // diagnostic sub codes
  localparam logic [4:0] DG_UNKNOWN  = 5'd0;
  localparam logic [4:0] DG_BANG     = 5'd1;
  localparam logic [4:0] DG_ESCAPE   = 5'd2;
  localparam logic [4:0] DG_BLOCK    = 5'd3;
  localparam logic [4:0] DG_UNCLOSED = 5'd4;

  localparam logic [4:0] CODE_NONE = 5'd0;
  localparam logic [62:0] VALUE_MAX = {63{1'b1}};

  localparam int KW_COUNT = 18;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;

  // spellings, first character in the most significant used byte
  localparam logic [47:0] KW_LIT [KW_COUNT] = '{
    48'("extern"), 48'("return"), 48'("end"), 48'("if"), 48'("else"),
    48'("elseif"), 48'("for"), 48'("true"), 48'("false"), 48'("void"),
    48'("bool"), 48'("string"), 48'("i8"), 48'("i16"), 48'("i32"),
    48'("i64"), 48'("f32"), 48'("f64")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd6, 3'd3, 3'd2, 3'd4, 3'd6, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4, 3'd6,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  typedef struct packed {
    tk_t         kind;
    logic [4:0]  code;
    logic [23:0] start;
    logic [23:0] len;
    logic [62:0] ival;
    logic        ovf;
    logic [7:0]  bad;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t [2:0] tok;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } kw_hit_t;

  function automatic tok_t mk_tok(input tk_t kind, input logic [4:0] code,
                                  input logic [23:0] start, input logic [23:0] len,
                                  input logic [62:0] ival, input logic ovf,
                                  input logic [7:0] bad);
    tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.start = start;
    t.len   = len;
    t.ival  = ival;
    t.ovf   = ovf;
    t.bad   = bad;
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // buffer holds the first character in its lowest byte
  function automatic kw_hit_t kw_find(input logic [47:0] buf48, input logic [2:0] len);
    kw_hit_t r;
    logic    ok;
    r = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      ok = (KW_LEN[k] == len);
      for (int j = 0; j < 6; j++) begin
        if (j < int'(KW_LEN[k])) begin
          if (buf48[8*j +: 8] != KW_LIT[k][8*(int'(KW_LEN[k]) - 1 - j) +: 8]) ok = 1'b0;
        end
      end
      if (ok) begin
        r.hit = 1'b1;
        r.idx = 5'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/slx_front.sv */
// lexer front: takes one byte per transaction and decides the tokens it causes
`default_nettype none
module slx_front import slx_pkg::*; #(
  parameter int POSITION_BITS     = 24,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_input,
  output bundle_t         bundle,
  output logic            push
);

  localparam int P  = POSITION_BITS;
  localparam int WB = 8 * KEYWORD_MAX_CHARS;

  mode_t          mode, mode_next;
  logic [P-1:0]   bpos, bpos_next;
  logic [P-1:0]   tstart, tstart_next;
  logic [P-1:0]   tlen, tlen_next;
  logic [WB-1:0]  wbuf, wbuf_next;
  logic           wlong, wlong_next;
  logic [62:0]    acc, acc_next;
  logic           spt, spt_next;
  logic           esc, esc_next;
  popr_t          popr, popr_next;
  logic           vsat, vsat_next;
  logic           bhash, bhash_next;

  tok_t [2:0]     toks;
  logic [1:0]     cnt;
  logic           run_idle;
  logic [66:0]    prod;
  kw_hit_t        kw;
  kw_hit_t        kw_end;
  logic [7:0]     b;
  logic [P-1:0]   p;

  function automatic logic [23:0] clip(input logic [P-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    return (v32 > 32'h00FF_FFFF) ? 24'hFF_FFFF : v32[23:0];
  endfunction

  function automatic logic [P-1:0] inc_sat(input logic [P-1:0] v);
    return (v == {P{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign b = char_byte;
  assign p = bpos;

  always_comb begin
    mode_next   = mode;
    bpos_next   = bpos;
    tstart_next = tstart;
    tlen_next   = tlen;
    wbuf_next   = wbuf;
    wlong_next  = wlong;
    acc_next    = acc;
    spt_next    = spt;
    esc_next    = esc;
    popr_next   = popr;
    vsat_next   = vsat;
    bhash_next  = bhash;
    toks        = '0;
    cnt         = 2'd0;
    run_idle    = 1'b0;
    kw_end      = '0;
    prod        = (67'(acc) << 3) + (67'(acc) << 1) + 67'(b - 8'h30);
    kw          = kw_find(wbuf[47:0], tlen[2:0]);

    case (mode)
      MD_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          if (tlen < P'(KEYWORD_MAX_CHARS)) wbuf_next = wbuf | (WB'(b) << {tlen, 3'b000});
          else wlong_next = 1'b1;
          tlen_next = inc_sat(tlen);
        end else begin
          if (!wlong && 32'(tlen) <= 32'd6 && kw.hit)
            toks[cnt] = mk_tok(TK_KEYWORD, kw.idx, clip(tstart), clip(tlen), '0, 1'b0, '0);
          else
            toks[cnt] = mk_tok(TK_IDENT, CODE_NONE, clip(tstart), clip(tlen), '0, 1'b0, '0);
          cnt = cnt + 2'd1;
          run_idle = 1'b1;
        end
      end
      MD_NUMBER: begin
        if (is_digit(b) || b == ".") begin
          tlen_next = inc_sat(tlen);
          if (b == ".") begin
            spt_next = 1'b1;
          end else if (!spt) begin
            if (prod[66:63] != 4'd0) begin
              acc_next  = VALUE_MAX;
              vsat_next = 1'b1;
            end else begin
              acc_next = prod[62:0];
            end
          end
        end else begin
          if (spt)
            toks[cnt] = mk_tok(TK_FLOAT, CODE_NONE, clip(tstart), clip(tlen), '0, 1'b0, '0);
          else
            toks[cnt] = mk_tok(TK_INT, CODE_NONE, clip(tstart), clip(tlen), acc, vsat, '0);
          cnt = cnt + 2'd1;
          run_idle = 1'b1;
        end
      end
      MD_STRING: begin
        tlen_next = inc_sat(tlen);
        if (esc) begin
          esc_next = 1'b0;
          if (b != "n" && b != "t" && b != "\\" && b != "\"") begin
            toks[cnt] = mk_tok(TK_DIAG, DG_ESCAPE, clip((p != '0) ? p - 1'b1 : p), 24'd2,
                               '0, 1'b0, b);
            cnt = cnt + 2'd1;
          end
        end else if (b == "\\") begin
          esc_next = 1'b1;
        end else if (b == "\"") begin
          toks[cnt] = mk_tok(TK_STRING, CODE_NONE, clip(tstart), clip(tlen_next), '0, 1'b0, '0);
          cnt = cnt + 2'd1;
          mode_next = MD_IDLE;
        end
      end
      MD_HASH: begin
        if (b == "#") begin
          mode_next  = MD_BLOCK;
          bhash_next = 1'b1;
        end else if (b == "\n") begin
          run_idle = 1'b1;
        end else begin
          mode_next = MD_LINE;
        end
      end
      MD_LINE: begin
        if (b == "\n") run_idle = 1'b1;
      end
      MD_BLOCK: begin
        if (b == "#" && bhash) mode_next = MD_IDLE;
        else bhash_next = (b == "#");
      end
      MD_OPER: begin
        if (b == "=") begin
          case (popr)
            PO_EQ:   toks[cnt] = mk_tok(TK_OPER, OP_EQ, clip(tstart), 24'd2, '0, 1'b0, '0);
            PO_LT:   toks[cnt] = mk_tok(TK_OPER, OP_LE, clip(tstart), 24'd2, '0, 1'b0, '0);
            PO_GT:   toks[cnt] = mk_tok(TK_OPER, OP_GE, clip(tstart), 24'd2, '0, 1'b0, '0);
            default: toks[cnt] = mk_tok(TK_OPER, OP_NE, clip(tstart), 24'd2, '0, 1'b0, '0);
          endcase
          cnt = cnt + 2'd1;
          mode_next = MD_IDLE;
        end else begin
          case (popr)
            PO_EQ:   toks[cnt] = mk_tok(TK_ASSIGN, CODE_NONE, clip(tstart), 24'd1, '0, 1'b0, '0);
            PO_LT:   toks[cnt] = mk_tok(TK_OPER, OP_LT, clip(tstart), 24'd1, '0, 1'b0, '0);
            PO_GT:   toks[cnt] = mk_tok(TK_OPER, OP_GT, clip(tstart), 24'd1, '0, 1'b0, '0);
            default: toks[cnt] = mk_tok(TK_DIAG, DG_BANG, clip(tstart), 24'd1, '0, 1'b0, "!");
          endcase
          cnt = cnt + 2'd1;
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      mode_next = MD_IDLE;
      if (b == "\n") begin
        toks[cnt] = mk_tok(TK_NEWLINE, CODE_NONE, clip(p), 24'd1, '0, 1'b0, '0);
        cnt = cnt + 2'd1;
      end else if (b == 8'd32 || b == 8'd9 || b == 8'd11 || b == 8'd12 || b == 8'd13) begin
        mode_next = MD_IDLE;
      end else if (is_alpha(b)) begin
        mode_next   = MD_IDENT;
        tstart_next = p;
        tlen_next   = P'(1);
        wbuf_next   = WB'(b);
        wlong_next  = 1'b0;
      end else if (is_digit(b)) begin
        mode_next   = MD_NUMBER;
        tstart_next = p;
        tlen_next   = P'(1);
        acc_next    = 63'(b - 8'h30);
        spt_next    = 1'b0;
        vsat_next   = 1'b0;
      end else if (b == "\"") begin
        mode_next   = MD_STRING;
        tstart_next = p;
        tlen_next   = P'(1);
        esc_next    = 1'b0;
      end else if (b == "#") begin
        mode_next   = MD_HASH;
        tstart_next = p;
        tlen_next   = P'(1);
      end else if (b == "=" || b == "<" || b == ">" || b == "!") begin
        mode_next   = MD_OPER;
        tstart_next = p;
        tlen_next   = P'(1);
        popr_next   = (b == "=") ? PO_EQ : (b == "<") ? PO_LT : (b == ">") ? PO_GT : PO_BANG;
      end else begin
        case (b)
          ",":     toks[cnt] = mk_tok(TK_COMMA, CODE_NONE, clip(p), 24'd1, '0, 1'b0, '0);
          ":":     toks[cnt] = mk_tok(TK_COLON, CODE_NONE, clip(p), 24'd1, '0, 1'b0, '0);
          "(":     toks[cnt] = mk_tok(TK_OPEN, CODE_NONE, clip(p), 24'd1, '0, 1'b0, '0);
          ")":     toks[cnt] = mk_tok(TK_CLOSE, CODE_NONE, clip(p), 24'd1, '0, 1'b0, '0);
          "+":     toks[cnt] = mk_tok(TK_OPER, OP_ADD, clip(p), 24'd1, '0, 1'b0, '0);
          "-":     toks[cnt] = mk_tok(TK_OPER, OP_SUB, clip(p), 24'd1, '0, 1'b0, '0);
          "*":     toks[cnt] = mk_tok(TK_OPER, OP_MUL, clip(p), 24'd1, '0, 1'b0, '0);
          "/":     toks[cnt] = mk_tok(TK_OPER, OP_DIV, clip(p), 24'd1, '0, 1'b0, '0);
          default: toks[cnt] = mk_tok(TK_DIAG, DG_UNKNOWN, clip(p), 24'd1, '0, 1'b0, b);
        endcase
        cnt = cnt + 2'd1;
      end
    end

    bpos_next = inc_sat(bpos);

    if (end_of_input) begin
      // close whatever token is still open, then the end marker
      case (mode_next)
        MD_IDENT: begin
          kw_end = kw_find(wbuf_next[47:0], tlen_next[2:0]);
          if (!wlong_next && 32'(tlen_next) <= 32'd6 && kw_end.hit)
            toks[cnt] = mk_tok(TK_KEYWORD, kw_end.idx,
                               clip(tstart_next), clip(tlen_next), '0, 1'b0, '0);
          else
            toks[cnt] = mk_tok(TK_IDENT, CODE_NONE, clip(tstart_next), clip(tlen_next),
                               '0, 1'b0, '0);
          cnt = cnt + 2'd1;
        end
        MD_NUMBER: begin
          if (spt_next)
            toks[cnt] = mk_tok(TK_FLOAT, CODE_NONE, clip(tstart_next), clip(tlen_next),
                               '0, 1'b0, '0);
          else
            toks[cnt] = mk_tok(TK_INT, CODE_NONE, clip(tstart_next), clip(tlen_next),
                               acc_next, vsat_next, '0);
          cnt = cnt + 2'd1;
        end
        MD_STRING: begin
          toks[cnt] = mk_tok(TK_DIAG, DG_UNCLOSED, clip(tstart_next), clip(tlen_next),
                             '0, 1'b0, "\"");
          cnt = cnt + 2'd1;
        end
        MD_BLOCK: begin
          toks[cnt] = mk_tok(TK_DIAG, DG_BLOCK, clip(tstart_next), 24'd2, '0, 1'b0, "#");
          cnt = cnt + 2'd1;
        end
        MD_OPER: begin
          case (popr_next)
            PO_EQ:   toks[cnt] = mk_tok(TK_ASSIGN, CODE_NONE, clip(tstart_next), 24'd1,
                                        '0, 1'b0, '0);
            PO_LT:   toks[cnt] = mk_tok(TK_OPER, OP_LT, clip(tstart_next), 24'd1, '0, 1'b0, '0);
            PO_GT:   toks[cnt] = mk_tok(TK_OPER, OP_GT, clip(tstart_next), 24'd1, '0, 1'b0, '0);
            default: toks[cnt] = mk_tok(TK_DIAG, DG_BANG, clip(tstart_next), 24'd1, '0, 1'b0, "!");
          endcase
          cnt = cnt + 2'd1;
        end
        default: cnt = cnt;
      endcase
      toks[cnt] = mk_tok(TK_END, CODE_NONE, clip(bpos_next), 24'd0, '0, 1'b0, '0);
      cnt = cnt + 2'd1;
      mode_next   = MD_IDLE;
      bpos_next   = '0;
      tstart_next = '0;
      tlen_next   = '0;
      wbuf_next   = '0;
      wlong_next  = 1'b0;
      acc_next    = '0;
      spt_next    = 1'b0;
      esc_next    = 1'b0;
      popr_next   = PO_EQ;
      vsat_next   = 1'b0;
      bhash_next  = 1'b0;
    end
  end

  assign bundle.cnt = cnt;
  assign bundle.tok = toks;
  assign push       = accept && (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MD_IDLE;
      bpos   <= '0;
      tstart <= '0;
      tlen   <= '0;
      wbuf   <= '0;
      wlong  <= 1'b0;
      acc    <= '0;
      spt    <= 1'b0;
      esc    <= 1'b0;
      popr   <= PO_EQ;
      vsat   <= 1'b0;
      bhash  <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      bpos   <= bpos_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      wbuf   <= wbuf_next;
      wlong  <= wlong_next;
      acc    <= acc_next;
      spt    <= spt_next;
      esc    <= esc_next;
      popr   <= popr_next;
      vsat   <= vsat_next;
      bhash  <= bhash_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/slx_fifo.sv */
// short queue of token bundles between lexer front and token output
`default_nettype none
module slx_fifo import slx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t wdata,
  input  wire logic    pop,
  output bundle_t      rdata,
  output logic         full,
  output logic         empty
);

  bundle_t        mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   fill;

  assign full  = (fill == (QAW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/slx_back.sv */
// token output: walks the head bundle one token per transaction
`default_nettype none
module slx_back import slx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire logic    empty,
  input  wire logic    out_stall,
  output logic         out_valid,
  output tok_t         tok,
  output logic         last,
  output logic         pop
);

  logic [1:0] idx;

  assign out_valid = !empty;
  assign tok       = head.tok[idx];
  assign last      = (idx == head.cnt - 2'd1);
  assign pop       = out_valid && !out_stall && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && !out_stall) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/source_lexer_stream.sv */
// top level of the streaming source lexer
// a byte's tokens are registered into the bundle queue, then offered from its head
// throughput: one byte per cycle while the token queue has room; tokens leave one per
//   cycle while the receiver does not stall, so a byte causing n tokens holds the output until all n have left
// the four-entry bundle queue between front and output sets how far input runs ahead
// reset: synchronous, clears lexer state and empties the queue
`default_nettype none
module source_lexer_stream import slx_pkg::*; #(
  parameter int POSITION_BITS     = 24,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [4:0]       sub_code,
  output logic [23:0]      start_pos,
  output logic [23:0]      token_len,
  output logic [62:0]      int_value,
  output logic             value_overflow,
  output logic [7:0]       bad_byte,
  output logic             last_of_run
);

  bundle_t fbundle, head;
  logic    push, pop, full, empty, accept;
  tok_t    tok;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  slx_front #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
  ) u_front (
    .clk(clk), .rst(rst), .accept(accept), .char_byte(char_byte),
    .end_of_input(end_of_input), .bundle(fbundle), .push(push)
  );

  slx_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(fbundle), .pop(pop),
    .rdata(head), .full(full), .empty(empty)
  );

  slx_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .out_stall(out_stall),
    .out_valid(out_valid), .tok(tok), .last(last_of_run), .pop(pop)
  );

  assign token_kind     = tok.kind;
  assign sub_code       = tok.code;
  assign start_pos      = tok.start;
  assign token_len      = tok.len;
  assign int_value      = tok.ival;
  assign value_overflow = tok.ovf;
  assign bad_byte       = tok.bad;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("bundle pushed into full queue");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind == TK_END) |-> (last_of_run && token_len == 24'd0))
    else $error("end token not last or nonzero length");
  a_ival_int: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_kind != TK_INT) |-> (int_value == '0 && !value_overflow))
    else $error("value on non-integer token");

endmodule
`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the streaming source lexer
`default_nettype none
module tb;
  import slx_pkg::*;

  typedef struct {
    tok_t t;
    bit   last;
  } lex_token_t;

  typedef struct {
    logic [7:0] ch;
    bit         eoi;
    bit         typed;
    tk_t        kind;
    logic [4:0] code;
  } source_row_t;

  localparam logic [4:0] KW_IF    = 5'd3;
  localparam int         IDLE_LIMIT = 2000;
  localparam int         LONG_HOLD  = 160;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_byte;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [4:0]  sub_code;
  logic [23:0] start_pos;
  logic [23:0] token_len;
  logic [62:0] int_value;
  logic        value_overflow;
  logic [7:0]  bad_byte;
  logic        last_of_run;

  source_lexer_stream DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_byte(char_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .sub_code(sub_code), .start_pos(start_pos),
    .token_len(token_len), .int_value(int_value), .value_overflow(value_overflow),
    .bad_byte(bad_byte), .last_of_run(last_of_run)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // lexer state mirrored for prediction
  mode_t       lx_mode;
  logic [23:0] lx_pos, lx_start, lx_len;
  logic [47:0] lx_word;
  bit          lx_word_long, lx_point, lx_escape, lx_sat, lx_block_hash;
  logic [62:0] lx_acc;
  popr_t       lx_pend;

  tok_t        step_tokens[$];
  lex_token_t  expected_tokens[$];
  logic [7:0]  source_bytes[$];

  string kw_words[KW_COUNT] = '{"extern", "return", "end", "if", "else", "elseif", "for",
    "true", "false", "void", "bool", "string", "i8", "i16", "i32", "i64", "f32", "f64"};

  int errors, bytes_sent, tokens_seen, sources_sent, hold_asks, idle_cycles;

  function automatic logic [23:0] sat_inc(input logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 24'd1;
  endfunction

  function automatic bit letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic put_token(input tk_t k, input logic [4:0] c, input logic [23:0] s,
                           input logic [23:0] l, input logic [62:0] v, input bit o,
                           input logic [7:0] b);
    tok_t t;
    if (step_tokens.size() < 3) begin
      t.kind = k; t.code = c; t.start = s; t.len = l; t.ival = v; t.ovf = o; t.bad = b;
      step_tokens.insert(step_tokens.size(), t);
    end
  endtask

  task automatic clear_lexer();
    lx_mode = MD_IDLE; lx_pos = '0; lx_start = '0; lx_len = '0; lx_word = '0;
    lx_word_long = 0; lx_acc = '0; lx_point = 0; lx_escape = 0; lx_sat = 0;
    lx_block_hash = 0; lx_pend = PO_EQ;
  endtask

  task automatic close_word();
    bit hit;
    hit = 0;
    if (!lx_word_long) begin
      for (int k = 0; k < KW_COUNT && !hit; k++) begin
        if (kw_words[k].len() == lx_len) begin
          hit = 1;
          for (int i = 0; i < kw_words[k].len(); i++)
            if (lx_word[8*i +: 8] != kw_words[k][i]) hit = 0;
          if (hit) put_token(TK_KEYWORD, 5'(k), lx_start, lx_len, '0, 0, '0);
        end
      end
    end
    if (!hit) put_token(TK_IDENT, CODE_NONE, lx_start, lx_len, '0, 0, '0);
  endtask

  task automatic close_number();
    if (lx_point) put_token(TK_FLOAT, CODE_NONE, lx_start, lx_len, '0, 0, '0);
    else put_token(TK_INT, CODE_NONE, lx_start, lx_len, lx_acc, lx_sat, '0);
  endtask

  task automatic close_operator();
    case (lx_pend)
      PO_EQ:   put_token(TK_ASSIGN, CODE_NONE, lx_start, 24'd1, '0, 0, '0);
      PO_LT:   put_token(TK_OPER, OP_LT, lx_start, 24'd1, '0, 0, '0);
      PO_GT:   put_token(TK_OPER, OP_GT, lx_start, 24'd1, '0, 0, '0);
      default: put_token(TK_DIAG, DG_BANG, lx_start, 24'd1, '0, 0, "!");
    endcase
  endtask

  task automatic open_token(input mode_t m, input logic [23:0] p);
    lx_mode = m; lx_start = p; lx_len = 24'd1;
  endtask

  task automatic idle_byte(input logic [7:0] b, input logic [23:0] p);
    lx_mode = MD_IDLE;
    if (b == "\n") put_token(TK_NEWLINE, CODE_NONE, p, 24'd1, '0, 0, '0);
    else if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D) begin
    end else if (letter(b)) begin
      open_token(MD_IDENT, p); lx_word = 48'(b); lx_word_long = 0;
    end else if (digit(b)) begin
      open_token(MD_NUMBER, p); lx_acc = 63'(b - "0"); lx_point = 0; lx_sat = 0;
    end else if (b == "\"") begin
      open_token(MD_STRING, p); lx_escape = 0;
    end else if (b == "#") open_token(MD_HASH, p);
    else if (b == "=" || b == "<" || b == ">" || b == "!") begin
      open_token(MD_OPER, p);
      lx_pend = (b == "=") ? PO_EQ : (b == "<") ? PO_LT : (b == ">") ? PO_GT : PO_BANG;
    end else begin
      case (b)
        ",":     put_token(TK_COMMA, CODE_NONE, p, 24'd1, '0, 0, '0);
        ":":     put_token(TK_COLON, CODE_NONE, p, 24'd1, '0, 0, '0);
        "(":     put_token(TK_OPEN, CODE_NONE, p, 24'd1, '0, 0, '0);
        ")":     put_token(TK_CLOSE, CODE_NONE, p, 24'd1, '0, 0, '0);
        "+":     put_token(TK_OPER, OP_ADD, p, 24'd1, '0, 0, '0);
        "-":     put_token(TK_OPER, OP_SUB, p, 24'd1, '0, 0, '0);
        "*":     put_token(TK_OPER, OP_MUL, p, 24'd1, '0, 0, '0);
        "/":     put_token(TK_OPER, OP_DIV, p, 24'd1, '0, 0, '0);
        default: put_token(TK_DIAG, DG_UNKNOWN, p, 24'd1, '0, 0, b);
      endcase
    end
  endtask

  task automatic lex_one(input logic [7:0] b, input logic [23:0] p);
    logic [63:0] d;
    case (lx_mode)
      MD_IDENT:
        if (letter(b) || digit(b) || b == "_") begin
          if (lx_len < 24'd6) lx_word[8*lx_len[2:0] +: 8] = b;
          else lx_word_long = 1;
          lx_len = sat_inc(lx_len);
        end else begin
          close_word(); idle_byte(b, p);
        end
      MD_NUMBER:
        if (digit(b) || b == ".") begin
          lx_len = sat_inc(lx_len);
          if (b == ".") lx_point = 1;
          else if (!lx_point) begin
            d = 64'(b - "0");
            if (64'(lx_acc) > (64'(VALUE_MAX) - d) / 10) begin
              lx_acc = VALUE_MAX; lx_sat = 1;
            end else lx_acc = 63'(64'(lx_acc) * 10 + d);
          end
        end else begin
          close_number(); idle_byte(b, p);
        end
      MD_STRING: begin
        lx_len = sat_inc(lx_len);
        if (lx_escape) begin
          lx_escape = 0;
          if (b != "n" && b != "t" && b != "\\" && b != "\"")
            put_token(TK_DIAG, DG_ESCAPE, (p > 0) ? p - 24'd1 : '0, 24'd2, '0, 0, b);
        end else if (b == "\\") lx_escape = 1;
        else if (b == "\"") begin
          put_token(TK_STRING, CODE_NONE, lx_start, lx_len, '0, 0, '0);
          lx_mode = MD_IDLE;
        end
      end
      MD_HASH:
        if (b == "#") begin
          lx_mode = MD_BLOCK; lx_block_hash = 1;
        end else if (b == "\n") idle_byte(b, p);
        else lx_mode = MD_LINE;
      MD_LINE:
        if (b == "\n") idle_byte(b, p);
      MD_BLOCK:
        if (b == "#" && lx_block_hash) lx_mode = MD_IDLE;
        else lx_block_hash = (b == "#");
      MD_OPER:
        if (b == "=") begin
          case (lx_pend)
            PO_EQ:   put_token(TK_OPER, OP_EQ, lx_start, 24'd2, '0, 0, '0);
            PO_LT:   put_token(TK_OPER, OP_LE, lx_start, 24'd2, '0, 0, '0);
            PO_GT:   put_token(TK_OPER, OP_GE, lx_start, 24'd2, '0, 0, '0);
            default: put_token(TK_OPER, OP_NE, lx_start, 24'd2, '0, 0, '0);
          endcase
          lx_mode = MD_IDLE;
        end else begin
          close_operator(); idle_byte(b, p);
        end
      default: idle_byte(b, p);
    endcase
  endtask

  // works out the tokens of one accepted byte and queues them
  task automatic predict_tokens(input logic [7:0] b, input bit eoi);
    lex_token_t e;
    step_tokens.delete();
    lex_one(b, lx_pos);
    lx_pos = sat_inc(lx_pos);
    if (eoi) begin
      case (lx_mode)
        MD_IDENT:  close_word();
        MD_NUMBER: close_number();
        MD_STRING: put_token(TK_DIAG, DG_UNCLOSED, lx_start, lx_len, '0, 0, "\"");
        MD_BLOCK:  put_token(TK_DIAG, DG_BLOCK, lx_start, 24'd2, '0, 0, "#");
        MD_OPER:   close_operator();
        default: ;
      endcase
      put_token(TK_END, CODE_NONE, lx_pos, '0, '0, 0, '0);
      clear_lexer();
    end
    foreach (step_tokens[i]) begin
      e.t = step_tokens[i];
      e.last = (i == step_tokens.size() - 1);
      expected_tokens.insert(expected_tokens.size(), e);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit eoi);
    @(negedge clk);
    in_valid <= 1'b1;
    char_byte <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(b, eoi);
    bytes_sent++;
    if (eoi) sources_sent++;
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    source_bytes.insert(source_bytes.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  // one lexeme of random content, mostly well formed
  task automatic push_piece();
    int n;
    string ops;
    ops = ",:()+-*/";
    case ($urandom_range(0, 11))
      0: push_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
      1: begin
        add_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                      : 8'($urandom_range("A", "Z")));
        repeat ($urandom_range(0, 9)) add_byte(word_char());
      end
      2: repeat ($urandom_range(1, 22)) add_byte(8'($urandom_range("0", "9")));
      3: begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
        repeat ($urandom_range(1, 2)) add_byte(".");
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("0", "9")));
      end
      4: begin
        add_byte("\"");
        repeat ($urandom_range(0, 6)) begin
          n = $urandom_range(0, 9);
          if (n < 2) begin
            add_byte("\\");
            case ($urandom_range(0, 5))
              0: add_byte("n");
              1: add_byte("t");
              2: add_byte("\\");
              3: add_byte("\"");
              default: add_byte(8'($urandom_range(0, 255)));
            endcase
          end else add_byte(8'($urandom_range(" ", "~")));
        end
        add_byte("\"");
      end
      5: begin
        add_byte("#");
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(" ", "~")));
        add_byte("\n");
      end
      6: begin
        push_text("##");
        repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(" ", "~")));
        push_text("##");
      end
      7: begin
        n = $urandom_range(0, 3);
        add_byte((n == 0) ? "=" : (n == 1) ? "<" : (n == 2) ? ">" : "!");
        if ($urandom_range(0, 1)) add_byte("=");
      end
      8: add_byte(ops[$urandom_range(0, 7)]);
      9: add_byte("\n");
      10: add_byte(8'($urandom_range(0, 255)));
      default: begin
        n = $urandom_range(0, 4);
        add_byte((n == 0) ? " " : (n == 1) ? 8'h09 : 8'(8'h0A + n));
      end
    endcase
    if ($urandom_range(0, 1)) add_byte(" ");
  endtask

  // output side: compare each token transaction with the oldest prediction
  always @(posedge clk) begin
    lex_token_t e;
    if (!rst && out_valid && !out_stall) begin
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind=%0d start=%0d", $time, token_kind, start_pos);
      end else begin
        e = expected_tokens.pop_front();
        if ({e.t.kind, e.t.code, e.t.start, e.t.len, e.t.ival, e.t.ovf, e.t.bad, e.last} !==
            {token_kind, sub_code, start_pos, token_len, int_value, value_overflow, bad_byte,
             last_of_run}) begin
          errors++;
          $display("%0t: token mismatch expected kind=%0d code=%0d start=%0d len=%0d",
                   $time, e.t.kind, e.t.code, e.t.start, e.t.len);
          $display("%0t:   expected val=%0d ovf=%0d bad=%0h last=%0d",
                   $time, e.t.ival, e.t.ovf, e.t.bad, e.last);
          $display("%0t:   actual   kind=%0d code=%0d start=%0d len=%0d",
                   $time, token_kind, sub_code, start_pos, token_len);
          $display("%0t:   actual   val=%0d ovf=%0d bad=%0h last=%0d",
                   $time, int_value, value_overflow, bad_byte, last_of_run);
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int seen, hold, pct;
    seen = 0; hold = 0; pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        hold = LONG_HOLD;
      end
      if ($urandom_range(0, 47) == 0) pct = $urandom_range(0, 2) * 35;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(0, 99) < pct);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  source_row_t rows[$];

  initial begin
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    char_byte = '0;
    end_of_input = 1'b0;
    errors = 0; bytes_sent = 0; tokens_seen = 0; sources_sent = 0; hold_asks = 0;
    idle_cycles = 0;
    clear_lexer();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    rows = '{
      '{"i", 0, 0, TK_END, CODE_NONE}, '{"f", 0, 0, TK_END, CODE_NONE},
      '{" ", 0, 1, TK_KEYWORD, KW_IF},
      '{"<", 0, 0, TK_END, CODE_NONE}, '{"=", 0, 1, TK_OPER, OP_LE},
      '{"!", 0, 0, TK_END, CODE_NONE}, '{"x", 0, 1, TK_DIAG, DG_BANG},
      '{",", 0, 1, TK_IDENT, CODE_NONE},
      '{"\"", 0, 0, TK_END, CODE_NONE}, '{"\\", 0, 0, TK_END, CODE_NONE},
      '{"q", 0, 1, TK_DIAG, DG_ESCAPE}, '{"\"", 0, 1, TK_STRING, CODE_NONE},
      '{8'hFF, 0, 1, TK_DIAG, DG_UNKNOWN}, '{8'h00, 0, 1, TK_DIAG, DG_UNKNOWN},
      '{"9", 0, 0, TK_END, CODE_NONE}, '{".", 0, 0, TK_END, CODE_NONE},
      '{"#", 0, 1, TK_FLOAT, CODE_NONE},
      '{"#", 0, 0, TK_END, CODE_NONE}, '{"#", 0, 0, TK_END, CODE_NONE},
      '{">", 0, 0, TK_END, CODE_NONE}, '{"(", 1, 1, TK_OPER, OP_GT},
      '{"#", 0, 0, TK_END, CODE_NONE}, '{"#", 1, 1, TK_DIAG, DG_BLOCK},
      '{"\"", 1, 1, TK_DIAG, DG_UNCLOSED}
    };
    foreach (rows[i]) begin
      send_byte(rows[i].ch, rows[i].eoi);
      if (rows[i].typed && (step_tokens.size() == 0 || step_tokens[0].kind != rows[i].kind
                            || step_tokens[0].code != rows[i].code)) begin
        errors++;
        $display("%0t: directed byte %0d expected kind=%0d code=%0d actual kind=%0d code=%0d",
                 $time, i, rows[i].kind, rows[i].code,
                 step_tokens.size() ? step_tokens[0].kind : TK_END,
                 step_tokens.size() ? step_tokens[0].code : CODE_NONE);
      end
    end

    // random sources, each ending on a byte marked as the last
    while (bytes_sent < 300) begin
      source_bytes.delete();
      repeat ($urandom_range(4, 12)) push_piece();
      if ($urandom_range(0, 3) == 0 && source_bytes.size() > 1)
        repeat ($urandom_range(1, 2)) void'(source_bytes.pop_back());
      if (sources_sent == 4) hold_asks++;
      if (sources_sent == 7) begin
        pause_input(1);
        while (expected_tokens.size() != 0) @(posedge clk);
      end
      burst = $urandom_range(1, 20);
      foreach (source_bytes[i]) begin
        send_byte(source_bytes[i], i == source_bytes.size() - 1);
        if (--burst == 0) begin
          pause_input($urandom_range(0, 2) ? 0 : $urandom_range(1, 6));
          burst = $urandom_range(1, 20);
        end
      end
    end
    @(negedge clk) in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0) errors++;
    $display("run covered %0d source bytes in %0d sources, %0d tokens checked",
             bytes_sent, sources_sent, tokens_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
